>>> rtl/pixel_blend_unit_assert.svh
// -----------------------------------------------------------------------------
// pixel_blend_unit assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// -----------------------------------------------------------------------------
`ifndef PIXEL_BLEND_UNIT_ASSERT_SVH
`define PIXEL_BLEND_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pixel_blend_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pixel_blend_unit: next-cycle check failed");

`endif

>>> rtl/pbu_pkg.sv
// -----------------------------------------------------------------------------
// pbu_pkg
// Shared types, widths and register codes of the pixel blend unit.
// -----------------------------------------------------------------------------
package pbu_pkg;

	localparam int PIXEL_W   = 32;
	localparam int CHAN_W    = 8;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TINT_COLOR  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR   = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [CHAN_W-1:0]  ALPHA_RESET = 8'hFF;
	localparam logic [PIXEL_W-1:0] TINT_RESET  = 32'h0000_0000;
	localparam logic [PIXEL_W-1:0] KEY_RESET   = 32'hFFFF_FFFF;

	// Blend operations.
	typedef enum logic [3:0] {
		MODE_NONE        = 4'd0,
		MODE_COPY        = 4'd1,
		MODE_KEY_COPY    = 4'd2,
		MODE_ADD         = 4'd3,
		MODE_MULTIPLY    = 4'd4,
		MODE_SUBTRACT    = 4'd5,
		MODE_SCREEN      = 4'd6,
		MODE_ALPHA       = 4'd7,
		MODE_BLACKEN     = 4'd8,
		MODE_WHITEN      = 4'd9,
		MODE_KEY_ADD     = 4'd10,
		MODE_AVERAGE     = 4'd11,
		MODE_KEY_BLACKEN = 4'd12,
		MODE_TINT        = 4'd13,
		MODE_RED         = 4'd14,
		MODE_EFFECT      = 4'd15
	} blend_mode_t;

	// One result item as it leaves the datapath.
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               we;
	} blend_result_t;

endpackage

>>> rtl/pbu_chan.sv
// -----------------------------------------------------------------------------
// pbu_chan
// Per-channel arithmetic: combines the destination, source and tint channels of one color.
// -----------------------------------------------------------------------------
module pbu_chan
	import pbu_pkg::*;
(
	input  blend_mode_t       mode,
	input  logic [CHAN_W-1:0] alpha_level,
	input  logic [CHAN_W-1:0] d,
	input  logic [CHAN_W-1:0] s,
	input  logic [CHAN_W-1:0] t,
	output logic [CHAN_W-1:0] result
);

	logic [CHAN_W:0]     sum_ds;
	logic [CHAN_W:0]     sum_sa;
	logic [2*CHAN_W-1:0] prod_xs;
	logic [CHAN_W-1:0]   inv_alpha;
	logic [2*CHAN_W-1:0] prod_da;
	logic [2*CHAN_W-1:0] prod_sa;
	logic [2*CHAN_W:0]   mix;
	logic [CHAN_W+1:0]   screen;
	logic [CHAN_W-1:0]   add_sat;

	// Shared products and sums.
	always_comb begin
		sum_ds    = {1'b0, d} + {1'b0, s};
		sum_sa    = {1'b0, s} + {1'b0, alpha_level};
		prod_xs   = ((mode == MODE_TINT) ? t : d) * s;
		inv_alpha = 8'hFF - alpha_level;
		prod_da   = d * inv_alpha;
		prod_sa   = s * alpha_level;
		mix       = {1'b0, prod_da} + {1'b0, prod_sa};
		screen    = {1'b0, sum_ds} - {2'b00, prod_xs[2*CHAN_W-1:CHAN_W]};
		add_sat   = sum_ds[CHAN_W] ? 8'hFF : sum_ds[CHAN_W-1:0];
	end

	// Select the operation of the current mode.
	always_comb begin
		case (mode) inside
			MODE_ADD, MODE_KEY_ADD: result = add_sat;
			MODE_MULTIPLY, MODE_TINT: result = prod_xs[2*CHAN_W-1:CHAN_W];
			MODE_SUBTRACT: result = (d > s) ? (d - s) : '0;
			MODE_SCREEN: result = (screen > 10'd255) ? 8'hFF : screen[CHAN_W-1:0];
			MODE_ALPHA: result = mix[2*CHAN_W-1:CHAN_W];
			MODE_BLACKEN, MODE_KEY_BLACKEN:
				result = (s < alpha_level) ? '0 : (s - alpha_level);
			MODE_WHITEN: result = sum_sa[CHAN_W] ? 8'hFF : sum_sa[CHAN_W-1:0];
			MODE_AVERAGE: result = sum_ds[CHAN_W:1];
			default: result = '0;
		endcase
	end

endmodule

>>> rtl/pbu_datapath.sv
// -----------------------------------------------------------------------------
// pbu_datapath
// Key and zero tests, mode decode and the three color channels of one item.
// -----------------------------------------------------------------------------
module pbu_datapath
	import pbu_pkg::*;
(
	input  blend_mode_t        mode,
	input  logic [CHAN_W-1:0]  alpha_level,
	input  logic [PIXEL_W-1:0] tint_color,
	input  logic [PIXEL_W-1:0] key_color,
	input  logic [PIXEL_W-1:0] src,
	input  logic [PIXEL_W-1:0] dst,
	output blend_result_t      result
);

	logic               is_key;
	logic               src_zero;
	logic               dst_zero;
	logic               dst_key;
	logic [CHAN_W-1:0]  out_a;
	logic [CHAN_W-1:0]  out_r;
	logic [CHAN_W-1:0]  out_g;
	logic [CHAN_W-1:0]  out_b;
	logic [PIXEL_W-1:0] combined;
	logic [PIXEL_W-1:0] px;
	logic               we;

	// Whole-pixel tests.
	assign is_key   = (src == key_color);
	assign src_zero = (src == '0);
	assign dst_zero = (dst == '0);
	assign dst_key  = (dst == key_color);

	// One arithmetic unit per color channel.
	pbu_chan u_chan_r (
		.mode        (mode),
		.alpha_level (alpha_level),
		.d           (dst[23:16]),
		.s           (src[23:16]),
		.t           (tint_color[23:16]),
		.result      (out_r)
	);

	pbu_chan u_chan_g (
		.mode        (mode),
		.alpha_level (alpha_level),
		.d           (dst[15:8]),
		.s           (src[15:8]),
		.t           (tint_color[15:8]),
		.result      (out_g)
	);

	pbu_chan u_chan_b (
		.mode        (mode),
		.alpha_level (alpha_level),
		.d           (dst[7:0]),
		.s           (src[7:0]),
		.t           (tint_color[7:0]),
		.result      (out_b)
	);

	// Alpha comes from the tint color in tint mode, else from the destination.
	always_comb begin
		out_a = (mode == MODE_TINT) ? tint_color[31:24] : dst[31:24];
		if (mode == MODE_RED) begin
			combined = {out_a, src[23:16], 16'h0000};
		end else begin
			combined = {out_a, out_r, out_g, out_b};
		end
	end

	// Decide whether the destination is written and with what.
	always_comb begin
		we = 1'b0;
		px = '0;
		unique case (mode) inside
			MODE_COPY: begin
				we = 1'b1;
				px = src;
			end
			MODE_KEY_COPY: begin
				we = !is_key;
				px = src;
			end
			MODE_ADD, MODE_SCREEN, MODE_KEY_ADD: begin
				we = !(src_zero || dst_key);
				px = is_key ? src : combined;
			end
			MODE_MULTIPLY, MODE_ALPHA, MODE_WHITEN, MODE_AVERAGE: begin
				we = !is_key;
				px = combined;
			end
			MODE_SUBTRACT: begin
				we = !src_zero && !dst_zero;
				px = combined;
			end
			MODE_BLACKEN: begin
				we = 1'b1;
				px = src_zero ? '0 : combined;
			end
			MODE_KEY_BLACKEN, MODE_TINT, MODE_RED: begin
				we = src_zero || !is_key;
				px = src_zero ? '0 : combined;
			end
			default: begin
				we = 1'b0;
				px = '0;
			end
		endcase
		result.we    = we;
		result.pixel = we ? px : '0;
	end

endmodule

>>> rtl/pixel_blend_unit.sv
// -----------------------------------------------------------------------------
// pixel_blend_unit
// Per-pixel blend stage of a 2D blitter with a transparent key color.
// -----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, src_pixel, dst_pixel) takes one
// source and one destination ARGB pixel per item. The output channel
// (out_valid, out_ready, out_pixel, write_enable) returns one item per input
// item, in order: the new destination pixel and its write enable.
// Configuration is written through cfg_we, cfg_index and cfg_data while no
// items are in flight; a write takes effect at the next clock edge.
// An accepted item passes the input register, then the result register, and
// out_valid rises once the result register holds it. Throughput is one item
// per cycle while out_ready stays high, set by the single combinational pass
// of the datapath between the two registers.
// Reset clears both pipeline stages and loads the register defaults (mode
// none, alpha 255, tint 0, key white). When the receiver stalls, the result
// register holds its item and one more item waits in the input register;
// in_ready then drops until out_ready returns.
// -----------------------------------------------------------------------------
module pixel_blend_unit
	import pbu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIXEL_W-1:0]   src_pixel,
	input  logic [PIXEL_W-1:0]   dst_pixel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIXEL_W-1:0]   out_pixel,
	output logic                 write_enable,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PIXEL_W-1:0]   cfg_data
);

	blend_mode_t        blend_mode_q;
	logic [CHAN_W-1:0]  alpha_level_q;
	logic [PIXEL_W-1:0] tint_color_q;
	logic [PIXEL_W-1:0] key_color_q;

	logic               valid_s1;
	logic [PIXEL_W-1:0] src_s1;
	logic [PIXEL_W-1:0] dst_s1;
	logic               valid_s2;
	logic [PIXEL_W-1:0] pixel_s2;
	logic               we_s2;

	logic               adv_s2;
	blend_result_t      result;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q  <= MODE_NONE;
			alpha_level_q <= ALPHA_RESET;
			tint_color_q  <= TINT_RESET;
			key_color_q   <= KEY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BLEND_MODE:  blend_mode_q  <= blend_mode_t'(cfg_data[3:0]);
				CFG_ALPHA_LEVEL: alpha_level_q <= cfg_data[CHAN_W-1:0];
				CFG_TINT_COLOR:  tint_color_q  <= cfg_data;
				CFG_KEY_COLOR:   key_color_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow control: the result register moves when empty or taken.
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			src_s1 <= src_pixel;
			dst_s1 <= dst_pixel;
		end
	end

	// Blend datapath.
	pbu_datapath u_datapath (
		.mode        (blend_mode_q),
		.alpha_level (alpha_level_q),
		.tint_color  (tint_color_q),
		.key_color   (key_color_q),
		.src         (src_s1),
		.dst         (dst_s1),
		.result      (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_s2 <= result.pixel;
			we_s2    <= result.we;
		end
	end

	assign out_valid    = valid_s2;
	assign out_pixel    = pixel_s2;
	assign write_enable = we_s2;

endmodule

>>> rtl/pbu_checker.sv
// -----------------------------------------------------------------------------
// pbu_checker
// Port-level checks of the pixel blend unit, bound to the top level.
// -----------------------------------------------------------------------------
`include "pixel_blend_unit_assert.svh"

module pbu_checker
	import pbu_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [PIXEL_W-1:0]   out_pixel,
	input logic                 write_enable
);

	// A stalled result item keeps its payload.
	`PBU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_pixel) && $stable(write_enable))

	// A skipped pixel always carries a zero pixel value.
	`PBU_ASSERT_NOW(a_skip_zero, clk, arst_n, out_valid && !write_enable, out_pixel == '0)

	// With no result waiting, the input side can never be blocked.
	`PBU_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// An accepted item, or an older one ahead of it, reaches the output through the input and result registers.
	`PBU_ASSERT_NOW(a_latency, clk, arst_n, in_valid && in_ready, ##2 out_valid)

endmodule

bind pixel_blend_unit pbu_checker u_pbu_checker (.*);

>>> verif/pixel_blend_unit_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pixel_blend_unit_tb
// Self-checking testbench for the pixel blend unit. Each accepted pixel pair is
// run through a local model of the blend and key rules. The expected pixel and
// write enable are queued, and every output item is compared with the oldest
// entry. Directed cases cover each mode and its skip and clear rules. Random
// blocks with random configuration follow, under several idle and stall
// patterns. A long output hold-off and a drained pause are also exercised.
// -----------------------------------------------------------------------------
module pixel_blend_unit_tb;
	import pbu_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned CHAN_MAX     = 255;
	localparam int unsigned IDLE_HEAVY   = 63;
	localparam int unsigned IDLE_LIGHT   = 21;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [PIXEL_W-1:0]   src_pixel    = '0;
	logic [PIXEL_W-1:0]   dst_pixel    = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [PIXEL_W-1:0]   out_pixel;
	logic                 write_enable;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_BLEND_MODE;
	logic [PIXEL_W-1:0]   cfg_data     = '0;

	// Local copy of the configuration registers, at their reset values.
	blend_mode_t          mode_cfg  = MODE_NONE;
	logic [CHAN_W-1:0]    alpha_cfg = ALPHA_RESET;
	logic [PIXEL_W-1:0]   tint_cfg  = TINT_RESET;
	logic [PIXEL_W-1:0]   key_cfg   = KEY_RESET;

	blend_result_t        blend_expected_q[$];
	int unsigned          mismatch_count  = 0;
	int unsigned          results_checked = 0;
	int unsigned          cycle_count     = 0;
	int unsigned          send_idle_pct   = 0;
	int unsigned          recv_stall_pct  = 0;
	int unsigned          hold_request    = 0;
	int unsigned          hold_served     = 0;
	int unsigned          hold_left       = 0;

	pixel_blend_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.src_pixel    (src_pixel),
		.dst_pixel    (dst_pixel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_pixel    (out_pixel),
		.write_enable (write_enable),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run-length guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// One color channel of the blend, saturated to 0..255.
	function automatic logic [CHAN_W-1:0] blend_channel(blend_mode_t m, logic [CHAN_W-1:0] d8,
			logic [CHAN_W-1:0] s8, logic [CHAN_W-1:0] t8);
		int unsigned d, s, t, a, v;
		d = d8;
		s = s8;
		t = t8;
		a = alpha_cfg;
		case (m)
			MODE_ADD, MODE_KEY_ADD:          v = d + s;
			MODE_MULTIPLY:                   v = (d * s) >> 8;
			MODE_SUBTRACT:                   v = (d > s) ? d - s : 0;
			MODE_SCREEN:                     v = d + s - ((d * s) >> 8);
			MODE_ALPHA:                      v = (d * (CHAN_MAX - a) + s * a) >> 8;
			MODE_BLACKEN, MODE_KEY_BLACKEN:  v = (s < a) ? 0 : s - a;
			MODE_WHITEN:                     v = s + a;
			MODE_AVERAGE:                    v = (d + s) >> 1;
			MODE_TINT:                       v = (t * s) >> 8;
			default:                         v = 0;
		endcase
		return (v > CHAN_MAX) ? 8'hFF : v[7:0];
	endfunction

	// Whole-pixel blend; alpha comes from the destination, or the tint in tint mode.
	function automatic logic [PIXEL_W-1:0] blend_pixel(blend_mode_t m, logic [PIXEL_W-1:0] src,
			logic [PIXEL_W-1:0] dst);
		logic [CHAN_W-1:0] al;
		al = (m == MODE_TINT) ? tint_cfg[31:24] : dst[31:24];
		if (m == MODE_RED) begin
			return {al, src[23:16], 16'h0000};
		end
		return {al,
			blend_channel(m, dst[23:16], src[23:16], tint_cfg[23:16]),
			blend_channel(m, dst[15:8], src[15:8], tint_cfg[15:8]),
			blend_channel(m, dst[7:0], src[7:0], tint_cfg[7:0])};
	endfunction

	// Expected output item for one pixel pair under the current configuration.
	function automatic blend_result_t predict_blend(logic [PIXEL_W-1:0] src, logic [PIXEL_W-1:0] dst);
		blend_result_t r;
		logic          is_key;
		r.we    = 1'b0;
		r.pixel = '0;
		is_key  = (src == key_cfg);
		case (mode_cfg)
			MODE_COPY: begin
				r.we    = 1'b1;
				r.pixel = src;
			end
			MODE_KEY_COPY: begin
				if (!is_key) begin
					r.we    = 1'b1;
					r.pixel = src;
				end
			end
			MODE_ADD, MODE_SCREEN, MODE_KEY_ADD: begin
				// A keyed source over a non-keyed destination is copied as is.
				if (src != '0 && dst != key_cfg) begin
					r.we    = 1'b1;
					r.pixel = is_key ? src : blend_pixel(mode_cfg, src, dst);
				end
			end
			MODE_MULTIPLY, MODE_ALPHA, MODE_WHITEN, MODE_AVERAGE: begin
				if (!is_key) begin
					r.we    = 1'b1;
					r.pixel = blend_pixel(mode_cfg, src, dst);
				end
			end
			MODE_SUBTRACT: begin
				if (src != '0 && dst != '0) begin
					r.we    = 1'b1;
					r.pixel = blend_pixel(mode_cfg, src, dst);
				end
			end
			MODE_BLACKEN: begin
				// Blacken ignores the key; a zero source clears the destination.
				r.we    = 1'b1;
				r.pixel = (src == '0) ? '0 : blend_pixel(mode_cfg, src, dst);
			end
			MODE_KEY_BLACKEN, MODE_TINT, MODE_RED: begin
				if (src == '0) begin
					r.we = 1'b1;
				end else if (!is_key) begin
					r.we    = 1'b1;
					r.pixel = blend_pixel(mode_cfg, src, dst);
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [PIXEL_W-1:0] want,
			input logic [PIXEL_W-1:0] got);
		$display("mismatch on %s at result %0d: expected %h, got %h",
			field, results_checked, want, got);
		mismatch_count++;
	endtask

	// Output items are taken at the next rising edge; check them at the falling edge before it.
	always @(negedge clk) begin : check_results
		blend_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (blend_expected_q.size() == 0) begin
				report_mismatch("unexpected item", '0, out_pixel);
			end else begin
				want = blend_expected_q.pop_front();
				if (out_pixel !== want.pixel) begin
					report_mismatch("out_pixel", want.pixel, out_pixel);
				end
				if (write_enable !== want.we) begin
					report_mismatch("write_enable", {31'h0, want.we}, {31'h0, write_enable});
				end
			end
			results_checked++;
		end
	end

	// Output ready: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_request != hold_served) begin
			hold_served <= hold_request;
			hold_left   <= HOLD_CYCLES;
			out_ready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one pixel pair and queue its expected result once it is accepted.
	task automatic send_pixels(input logic [PIXEL_W-1:0] src, input logic [PIXEL_W-1:0] dst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		src_pixel <= src;
		dst_pixel <= dst;
		@(negedge clk);
		while (!in_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		blend_expected_q.push_back(predict_blend(src, dst));
	endtask

	// Stop offering items and wait until every expected result has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (blend_expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four registers back to back while the block is idle.
	task automatic apply_config(input blend_mode_t m, input logic [CHAN_W-1:0] a,
			input logic [PIXEL_W-1:0] t, input logic [PIXEL_W-1:0] k);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BLEND_MODE;
		cfg_data  <= {28'h0, m};
		@(posedge clk);
		cfg_index <= CFG_ALPHA_LEVEL;
		cfg_data  <= {24'h0, a};
		@(posedge clk);
		cfg_index <= CFG_TINT_COLOR;
		cfg_data  <= t;
		@(posedge clk);
		cfg_index <= CFG_KEY_COLOR;
		cfg_data  <= k;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mode_cfg  = m;
		alpha_cfg = a;
		tint_cfg  = t;
		key_cfg   = k;
	endtask

	task automatic run_case(input blend_mode_t m, input logic [CHAN_W-1:0] a,
			input logic [PIXEL_W-1:0] t, input logic [PIXEL_W-1:0] k,
			input logic [PIXEL_W-1:0] src, input logic [PIXEL_W-1:0] dst);
		apply_config(m, a, t, k);
		send_pixels(src, dst);
	endtask

	// Random source pixel, biased toward zero, the key and all ones.
	function automatic logic [PIXEL_W-1:0] pick_src();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 12) return '0;
		if (r < 27) return key_cfg;
		if (r < 32) return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// Random destination pixel, biased toward zero and the key.
	function automatic logic [PIXEL_W-1:0] pick_dst();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 20) return key_cfg;
		return $urandom;
	endfunction

	task automatic random_config();
		blend_mode_t       m;
		logic [CHAN_W-1:0] a;
		logic [PIXEL_W-1:0] t, k;
		m = blend_mode_t'($urandom_range(15));
		case ($urandom_range(3))
			0:       a = 8'h00;
			1:       a = 8'hFF;
			default: a = 8'($urandom);
		endcase
		case ($urandom_range(3))
			0:       t = 32'h0000_0000;
			1:       t = 32'hFFFF_FFFF;
			default: t = $urandom;
		endcase
		case ($urandom_range(3))
			0:       k = 32'h0000_0000;
			1:       k = 32'hFFFF_FFFF;
			default: k = $urandom;
		endcase
		apply_config(m, a, t, k);
	endtask

	// With the reset configuration (mode none) nothing is written.
	task automatic test_reset_defaults();
		send_pixels(32'hFFFF_FFFF, 32'h0000_0000);
		send_pixels(32'h0000_0000, 32'hFFFF_FFFF);
		drain_results();
	endtask

	// Every mode at least once, plus its skip, clear and saturation corners.
	task automatic test_directed_cases();
		run_case(MODE_NONE, 8'hFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		run_case(MODE_EFFECT, 8'h80, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0);
		run_case(MODE_COPY, 8'hFF, 32'h0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
		run_case(MODE_KEY_COPY, 8'hFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555);
		run_case(MODE_KEY_COPY, 8'hFF, 32'h0, 32'h0000_0000, 32'h0000_0000, 32'h5555_5555);
		run_case(MODE_KEY_COPY, 8'hFF, 32'h0, 32'h0000_0000, 32'h1234_5678, 32'h5555_5555);
		// Add family: zero source, keyed destination, keyed source, saturation.
		run_case(MODE_ADD, 8'hFF, 32'h0, 32'h1122_3344, 32'h0000_0000, 32'h0101_0101);
		run_case(MODE_ADD, 8'hFF, 32'h0, 32'h1122_3344, 32'h0101_0101, 32'h1122_3344);
		run_case(MODE_ADD, 8'hFF, 32'h0, 32'h1122_3344, 32'h1122_3344, 32'h0000_0000);
		run_case(MODE_ADD, 8'hFF, 32'h0, 32'h1122_3344, 32'h80FF_7F01, 32'h7F80_817F);
		run_case(MODE_KEY_ADD, 8'hFF, 32'h0, 32'hFFFF_FFFF, 32'h80FF_7F01, 32'h7F80_817F);
		run_case(MODE_SCREEN, 8'hFF, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_case(MODE_MULTIPLY, 8'hFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_case(MODE_MULTIPLY, 8'hFF, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Subtract: zero destination skips, underflow clamps at zero.
		run_case(MODE_SUBTRACT, 8'hFF, 32'h0, 32'hFFFF_FFFF, 32'h1010_1010, 32'h0000_0000);
		run_case(MODE_SUBTRACT, 8'hFF, 32'h0, 32'hFFFF_FFFF, 32'h10FF_0120, 32'h8080_0210);
		run_case(MODE_ALPHA, 8'h00, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8040_20FF);
		run_case(MODE_ALPHA, 8'hFF, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8040_20FF);
		// Blacken ignores the key and clears on a zero source.
		run_case(MODE_BLACKEN, 8'h40, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678);
		run_case(MODE_BLACKEN, 8'h40, 32'h0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678);
		run_case(MODE_WHITEN, 8'hFF, 32'h0, 32'h0000_0000, 32'h0102_03FE, 32'hAB00_0000);
		run_case(MODE_AVERAGE, 8'hFF, 32'h0, 32'h0000_0000, 32'hFEFE_FEFE, 32'hFFFF_FFFF);
		run_case(MODE_KEY_BLACKEN, 8'h20, 32'h0, 32'h1234_5678, 32'h1234_5678, 32'h0000_0000);
		run_case(MODE_KEY_BLACKEN, 8'h20, 32'h0, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF);
		run_case(MODE_TINT, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8080_80FF, 32'h0000_0000);
		run_case(MODE_TINT, 8'hFF, 32'hA0C0_E0FF, 32'h0000_0001, 32'h0000_0000, 32'h5555_5555);
		run_case(MODE_RED, 8'hFF, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hAB00_0000);
		drain_results();
	endtask

	// Blocks of random pixel pairs, each under a fresh random configuration.
	task automatic test_random_blend(input int unsigned blocks);
		int unsigned n;
		for (int b = 0; b < blocks; b++) begin
			random_config();
			n = $urandom_range(20, 36);
			for (int i = 0; i < n; i++) begin
				send_pixels(pick_src(), pick_dst());
			end
		end
		drain_results();
	endtask

	// The output holds off for a long stretch while the input keeps offering items.
	task automatic test_output_holdoff();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		apply_config(MODE_ALPHA, 8'h80, $urandom, 32'hFFFF_FFFF);
		hold_request++;
		for (int i = 0; i < 40; i++) begin
			send_pixels(pick_src(), pick_dst());
		end
		drain_results();
	endtask

	// The input pauses until all results are out, then resumes.
	task automatic test_pause_and_resume();
		send_idle_pct  = 0;
		recv_stall_pct = IDLE_LIGHT;
		apply_config(MODE_SCREEN, 8'h10, 32'h0, $urandom);
		for (int i = 0; i < 12; i++) begin
			send_pixels(pick_src(), pick_dst());
		end
		drain_results();
		for (int i = 0; i < 12; i++) begin
			send_pixels(pick_src(), pick_dst());
		end
		drain_results();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = IDLE_LIGHT;
		recv_stall_pct = IDLE_LIGHT;
		test_reset_defaults();
		test_directed_cases();

		// Random traffic under each idle pattern.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_blend(8);
		send_idle_pct  = IDLE_HEAVY;
		recv_stall_pct = 0;
		test_random_blend(8);
		send_idle_pct  = 0;
		recv_stall_pct = IDLE_HEAVY;
		test_random_blend(8);
		send_idle_pct  = IDLE_LIGHT;
		recv_stall_pct = IDLE_LIGHT;
		test_random_blend(8);

		test_output_holdoff();
		test_pause_and_resume();

		drain_results();
		if (mismatch_count == 0 && blend_expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
